/* hdl/lsa_pkg.sv */
// Package for the log segment append allocator: sizes, status codes,
// command codes, the item structs and the pool offset function.
// No dependencies.
package lsa_pkg;

  localparam int unsigned SegmentBytes       = 4096;
  localparam int unsigned MaxSegments        = 1024;
  localparam int unsigned SegmentHeaderBytes = 24;
  localparam int unsigned EntryHeaderBytes   = 16;
  localparam int unsigned PoolHeaderBytes    = 128;

  // Segment index, link (index plus the none marker) and position widths.
  localparam int unsigned SEG_W  = $clog2(MaxSegments);
  localparam int unsigned LINK_W = $clog2(MaxSegments + 1);
  localparam int unsigned POS_W  = 13;
  localparam int unsigned OFF_W  = 24;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned CNT_W  = 11;

  localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(MaxSegments);
  localparam logic [POS_W-1:0]  CAPACITY  = POS_W'(SegmentBytes - SegmentHeaderBytes);
  localparam logic [POS_W-1:0]  ENTRY_HDR = POS_W'(EntryHeaderBytes);

  localparam logic CMD_FORMAT = 1'b0;
  localparam logic CMD_APPEND = 1'b1;

  typedef enum logic [1:0] {
    ST_APPENDED  = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_FORMATTED = 2'd3
  } lsa_status_e;

  typedef struct packed {
    logic             command;
    logic [LEN_W-1:0] entry_length;
  } lsa_req_t;

  typedef struct packed {
    lsa_status_e      status;
    logic [OFF_W-1:0] entry_offset;
    logic             pad_written;
    logic [OFF_W-1:0] pad_offset;
    logic             segment_switched;
    logic [SEG_W-1:0] head_index;
    logic [CNT_W-1:0] used_count;
  } lsa_rsp_t;

  // Byte offset of a position inside a segment, counted from the pool start.
  function automatic logic [OFF_W-1:0] pool_offset(input logic [SEG_W-1:0] seg,
                                                   input logic [POS_W-1:0] pos);
    logic [OFF_W-1:0] base;
    base = OFF_W'(PoolHeaderBytes + SegmentHeaderBytes);
    return base + OFF_W'(seg) * OFF_W'(SegmentBytes) + OFF_W'(pos);
  endfunction

endpackage

/* hdl/lsa_link_ram.sv */
// Generic single-write, single-read synchronous RAM holding the segment links.
// Read data is registered. No dependencies.
module lsa_link_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hdl/lsa_cfg_regs.sv */
// Configuration register file behind the APB-style port: holds segment_count
// and hands the saturated count to the controller. Depends on lsa_pkg.
module lsa_cfg_regs
  import lsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CNT_W-1:0] seg_count_o
);

  logic [CNT_W-1:0] seg_count_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && !paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= CNT_W'(MaxSegments);
    end else if (wr_en) begin
      seg_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, seg_count_q};

  // The format walk only ever sees a count in 1..MaxSegments.
  always_comb begin
    if (seg_count_q == '0) begin
      seg_count_o = CNT_W'(1);
    end else if (seg_count_q > CNT_W'(MaxSegments)) begin
      seg_count_o = CNT_W'(MaxSegments);
    end else begin
      seg_count_o = seg_count_q;
    end
  end

endmodule

/* hdl/log_segment_append_allocator.sv */
// Top level of the log segment append allocator: command handshake, controller
// and link memory. Depends on lsa_pkg, lsa_cfg_regs and lsa_link_ram.
//
//   Channel   Direction  Handshake                     Payload
//   command   in         start high while busy low     req_i (lsa_req_t)
//   result    out        result_valid_o, one cycle     rsp_o (lsa_rsp_t)
//   config    in/out     APB setup + access, no wait   segment_count at 0x0
//
// An append that fits the head segment, or is rejected, needs no busy state: its
// result shows the cycle after start and busy stays low.
// An append that takes a new free segment needs the link of that segment from
// the link memory, whose read port is registered, so it stays busy in S_TAKE.
// A format writes one link per cycle for the configured segment count, then
// reads the first link in S_FMT_READ and takes segment 0 in S_TAKE.
// Reset leaves the pool unformatted (no head, no free segments); the link
// memory is not cleared, since format writes every link it later reads.
// The receiver cannot stall, so a result is strobed exactly once.
module log_segment_append_allocator
  import lsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  lsa_req_t    req_i,
  output logic        result_valid_o,
  output lsa_rsp_t    rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Controller states.
  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_FORMAT   = 2'd1;
  localparam logic [1:0] S_FMT_READ = 2'd2;
  localparam logic [1:0] S_TAKE     = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  seg_count;
  logic [CNT_W-1:0]  fmt_n_q, fmt_n_d;
  logic [SEG_W-1:0]  sweep_q, sweep_d;
  logic [LINK_W-1:0] head_q, head_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [LINK_W-1:0] free_first_q, free_first_d;
  logic [LINK_W-1:0] used_last_q, used_last_d;
  logic [CNT_W-1:0]  used_cnt_q, used_cnt_d;
  logic [POS_W-1:0]  pend_size_q, pend_size_d;
  logic              pend_fmt_q, pend_fmt_d;
  logic              pad_w_q, pad_w_d;
  logic [OFF_W-1:0]  pad_off_q, pad_off_d;
  logic              valid_q, valid_d;
  lsa_rsp_t          rsp_q, rsp_d;

  // Link memory ports.
  logic              ram_we, ram_re;
  logic [SEG_W-1:0]  ram_waddr, ram_raddr;
  logic [LINK_W-1:0] ram_wdata, ram_rdata;

  logic              accept;
  logic [POS_W-1:0]  size;
  logic [POS_W-1:0]  room;
  logic [CNT_W-1:0]  sweep_next;

  lsa_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .seg_count_o(seg_count)
  );

  lsa_link_ram #(
    .DEPTH(MaxSegments),
    .WIDTH(LINK_W)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Entry size is header plus payload; it always fits in POS_W bits.
  assign size       = ENTRY_HDR + POS_W'(req_i.entry_length);
  assign room       = (pos_q <= CAPACITY) ? (CAPACITY - pos_q) : '0;
  assign sweep_next = CNT_W'(sweep_q) + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    fmt_n_d      = fmt_n_q;
    sweep_d      = sweep_q;
    head_d       = head_q;
    pos_d        = pos_q;
    free_first_d = free_first_q;
    used_last_d  = used_last_q;
    used_cnt_d   = used_cnt_q;
    pend_size_d  = pend_size_q;
    pend_fmt_d   = pend_fmt_q;
    pad_w_d      = pad_w_q;
    pad_off_d    = pad_off_q;
    valid_d      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = NONE_MARK;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    rsp_d                  = rsp_q;
    rsp_d.status           = ST_APPENDED;
    rsp_d.entry_offset     = '0;
    rsp_d.pad_written      = 1'b0;
    rsp_d.pad_offset       = '0;
    rsp_d.segment_switched = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.command == CMD_FORMAT) begin
            // Clear the used chain now; the link walk follows.
            fmt_n_d     = seg_count;
            sweep_d     = '0;
            used_last_d = NONE_MARK;
            used_cnt_d  = '0;
            head_d      = NONE_MARK;
            state_d     = S_FORMAT;
          end else if (size > CAPACITY) begin
            // An entry that can never fit is rejected without side effects.
            valid_d      = 1'b1;
            rsp_d.status = ST_TOO_LARGE;
          end else if (head_q >= NONE_MARK) begin
            // No head yet: take a free segment, nothing is retired.
            pad_w_d     = 1'b0;
            pad_off_d   = '0;
            pend_size_d = size;
            pend_fmt_d  = 1'b0;
            if (free_first_q >= NONE_MARK) begin
              valid_d      = 1'b1;
              rsp_d.status = ST_NO_SPACE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = free_first_q[SEG_W-1:0];
              head_d    = free_first_q;
              state_d   = S_TAKE;
            end
          end else if (room >= size) begin
            // Fits in the head segment: place it right away.
            valid_d            = 1'b1;
            rsp_d.entry_offset = pool_offset(head_q[SEG_W-1:0], pos_q);
            pos_d              = pos_q + size;
          end else begin
            // Close the head segment, append it to the used chain and switch if a segment is free.
            pad_w_d   = (room >= ENTRY_HDR);
            pad_off_d = (room >= ENTRY_HDR) ? pool_offset(head_q[SEG_W-1:0], pos_q) : '0;
            if (used_last_q < NONE_MARK) begin
              ram_we    = 1'b1;
              ram_waddr = used_last_q[SEG_W-1:0];
              ram_wdata = head_q;
            end
            used_last_d = head_q;
            used_cnt_d  = used_cnt_q + CNT_W'(1);
            pend_size_d = size;
            pend_fmt_d  = 1'b0;
            if (free_first_q >= NONE_MARK) begin
              head_d            = NONE_MARK;
              valid_d           = 1'b1;
              rsp_d.status      = ST_NO_SPACE;
              rsp_d.pad_written = pad_w_d;
              rsp_d.pad_offset  = pad_off_d;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = free_first_q[SEG_W-1:0];
              head_d    = free_first_q;
              state_d   = S_TAKE;
            end
          end
        end
      end

      S_FORMAT: begin
        // Link segment i to i+1, the last one to the none marker.
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = (sweep_next < fmt_n_q) ? LINK_W'(sweep_next) : NONE_MARK;
        sweep_d   = sweep_q + SEG_W'(1);
        if (sweep_next >= fmt_n_q) begin
          state_d = S_FMT_READ;
        end
      end

      S_FMT_READ: begin
        // Segment 0 heads the fresh free chain and becomes the head.
        ram_re      = 1'b1;
        ram_raddr   = '0;
        head_d      = '0;
        pend_fmt_d  = 1'b1;
        pad_w_d     = 1'b0;
        pad_off_d   = '0;
        pend_size_d = '0;
        state_d     = S_TAKE;
      end

      S_TAKE: begin
        // The taken segment's link has arrived: it is the new free head.
        free_first_d = (ram_rdata >= NONE_MARK) ? NONE_MARK : ram_rdata;
        ram_we       = 1'b1;
        ram_waddr    = head_q[SEG_W-1:0];
        ram_wdata    = NONE_MARK;
        pos_d        = pend_size_q;
        valid_d      = 1'b1;
        state_d      = S_IDLE;
        if (pend_fmt_q) begin
          rsp_d.status = ST_FORMATTED;
        end else begin
          rsp_d.entry_offset     = pool_offset(head_q[SEG_W-1:0], '0);
          rsp_d.pad_written      = pad_w_q;
          rsp_d.pad_offset       = pad_off_q;
          rsp_d.segment_switched = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.head_index = (head_d < NONE_MARK) ? head_d[SEG_W-1:0] : '0;
    rsp_d.used_count = used_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= NONE_MARK;
      pos_q        <= '0;
      free_first_q <= NONE_MARK;
      used_last_q  <= NONE_MARK;
      used_cnt_q   <= '0;
      pend_fmt_q   <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      pos_q        <= pos_d;
      free_first_q <= free_first_d;
      used_last_q  <= used_last_d;
      used_cnt_q   <= used_cnt_d;
      pend_fmt_q   <= pend_fmt_d;
      valid_q      <= valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    fmt_n_q     <= fmt_n_d;
    sweep_q     <= sweep_d;
    pend_size_q <= pend_size_d;
    pad_w_q     <= pad_w_d;
    pad_off_q   <= pad_off_d;
    rsp_q       <= rsp_d;
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  // A retire write and a link read in the same cycle never hit one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("link memory read and write collide");

  // While a segment is the head, its position never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q < NONE_MARK) |-> (pos_q <= CAPACITY))
    else $error("head position beyond segment capacity");

  // A segment take is always prepared by a link read in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAKE) |-> $past(ram_re))
    else $error("segment take without link read");

  // A format result reports an empty used chain and segment 0 as head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.status == ST_FORMATTED)
      |-> (rsp_o.used_count == '0 && rsp_o.head_index == '0))
    else $error("format result with stale chain state");

  // A successful append always leaves a valid head behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.status == ST_APPENDED) |-> (head_q < NONE_MARK))
    else $error("append reported without a head segment");

endmodule

/* tb/sv/log_segment_append_allocator_tb.sv */
// Self-checking testbench for the log segment append allocator.
// Depends on lsa_pkg and log_segment_append_allocator; drives commands
// and the segment_count register, and checks every result against a predictor.
module log_segment_append_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsa_pkg::*;

  // Byte address of the segment_count register on the configuration port.
  localparam logic [2:0] REG_SEGMENT_COUNT = 3'd0;
  // Cycles without any handshake before the run is declared hung. The
  // slowest item is a full-size format behind the longest plausible
  // sender gap, so this leaves several times the margin.
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned NUM_PHASES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 160;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  lsa_req_t    req_i   = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        result_valid_o;
  lsa_rsp_t    rsp_o;
  logic [31:0] prdata;
  logic        pready;

  log_segment_append_allocator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Items waiting to be driven, and the allocations the block owes us.
  lsa_req_t    pending_cmds[$];
  lsa_rsp_t    expected_allocs[$];
  int unsigned cmds_issued  = 0;
  int unsigned allocs_seen  = 0;
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  // Chance, in percent, that the sender sits out a cycle it could use.
  int unsigned idle_pct     = 25;

  // ---------------------------------------------------------------------
  // Predictor state: our own view of the segment pool. Only the parts that
  // can show up in a result are tracked; per-segment fill levels and the
  // tail of the free chain never influence an output.
  // ---------------------------------------------------------------------
  logic [LINK_W-1:0] seg_link [MaxSegments];
  logic [LINK_W-1:0] pred_head     = NONE_MARK;
  logic [POS_W-1:0]  head_pos      = '0;
  logic [LINK_W-1:0] free_head     = NONE_MARK;
  logic [LINK_W-1:0] used_tail     = NONE_MARK;
  logic [CNT_W-1:0]  used_segs     = '0;
  logic [CNT_W-1:0]  seg_count_cfg = CNT_W'(MaxSegments);

  // Pool byte offset of a position in a segment, cut to the port width.
  function automatic logic [OFF_W-1:0] seg_byte_offset(input logic [LINK_W-1:0] seg,
                                                       input logic [POS_W-1:0] pos);
    int unsigned off;
    off = PoolHeaderBytes + SegmentHeaderBytes + int'(seg) * SegmentBytes + int'(pos);
    return OFF_W'(off);
  endfunction

  // Pop the first free segment into the head; an empty chain leaves no head.
  function automatic bit claim_free_segment();
    if (free_head == NONE_MARK) begin
      pred_head = NONE_MARK;
      return 1'b0;
    end
    pred_head = free_head;
    free_head = seg_link[pred_head[SEG_W-1:0]];
    seg_link[pred_head[SEG_W-1:0]] = NONE_MARK;
    head_pos  = '0;
    return 1'b1;
  endfunction

  // Expected result of one command, advancing the predicted pool state.
  function automatic lsa_rsp_t next_allocation(input lsa_req_t req);
    lsa_rsp_t    r;
    int unsigned n;
    int unsigned need;
    int unsigned room;
    int unsigned i;
    bit          ok;
    r        = '0;
    r.status = ST_APPENDED;
    if (req.command == CMD_FORMAT) begin
      // An out-of-range count is clamped to 1..MaxSegments at format time.
      n = seg_count_cfg;
      if (n < 1) n = 1;
      if (n > MaxSegments) n = MaxSegments;
      for (i = 0; i < MaxSegments; i++) begin
        seg_link[i] = (i + 1 < n) ? LINK_W'(i + 1) : NONE_MARK;
      end
      free_head = '0;
      used_tail = NONE_MARK;
      used_segs = '0;
      pred_head = NONE_MARK;
      void'(claim_free_segment());
      r.status = ST_FORMATTED;
    end else begin
      need = EntryHeaderBytes + int'(req.entry_length);
      ok   = 1'b1;
      // An entry bigger than a whole segment is refused before anything else.
      if (need > CAPACITY) begin
        r.status = ST_TOO_LARGE;
        ok       = 1'b0;
      end
      // No head yet (never formatted, or the pool ran dry): grab a free one
      // without retiring anything.
      if (ok && pred_head == NONE_MARK) begin
        if (!claim_free_segment()) begin
          r.status = ST_NO_SPACE;
          ok       = 1'b0;
        end else begin
          r.segment_switched = 1'b1;
        end
      end
      if (ok) begin
        room = (head_pos <= CAPACITY) ? int'(CAPACITY) - int'(head_pos) : 0;
        if (room < need) begin
          // Close the old head with a pad header when one still fits.
          if (room >= EntryHeaderBytes) begin
            r.pad_written = 1'b1;
            r.pad_offset  = seg_byte_offset(pred_head, head_pos);
          end
          if (used_tail != NONE_MARK) seg_link[used_tail[SEG_W-1:0]] = pred_head;
          used_tail = pred_head;
          used_segs = used_segs + CNT_W'(1);
          // The old head stays retired even when no replacement exists.
          if (!claim_free_segment()) begin
            r.status = ST_NO_SPACE;
            ok       = 1'b0;
          end else begin
            r.segment_switched = 1'b1;
          end
        end
      end
      if (ok) begin
        r.entry_offset = seg_byte_offset(pred_head, head_pos);
        head_pos       = head_pos + POS_W'(need);
      end
    end
    r.head_index = (pred_head == NONE_MARK) ? '0 : pred_head[SEG_W-1:0];
    r.used_count = used_segs;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents the next pending item whenever the previous one has
  // been taken (or none was up), unless it decides to idle this cycle.
  // start is only ever assigned once per edge, so a back-to-back item keeps
  // start high without a glitch.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && (!start || !busy)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        req_i <= pending_cmds.pop_front();
        cmds_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on every accepted item and checks every strobed
  // result against the oldest prediction. The prediction is queued before
  // the result is looked at, so the check holds even if a result were to
  // appear in the same cycle as its item.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    lsa_rsp_t want;
    if (rst_ni) begin
      if (start && !busy) expected_allocs.push_back(next_allocation(req_i));
      if (result_valid_o) begin
        if (expected_allocs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no item outstanding: status=%0d offset=%h",
                     $realtime, rsp_o.status, rsp_o.entry_offset);
          end
        end else begin
          want = expected_allocs.pop_front();
          allocs_seen++;
          if (rsp_o.status !== want.status || rsp_o.entry_offset !== want.entry_offset ||
              rsp_o.pad_written !== want.pad_written ||
              rsp_o.pad_offset !== want.pad_offset ||
              rsp_o.segment_switched !== want.segment_switched ||
              rsp_o.head_index !== want.head_index ||
              rsp_o.used_count !== want.used_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch on result %0d", $realtime, allocs_seen);
              $display("  expected status=%0d offset=%h pad=%0d/%h switched=%0d head=%0d used=%0d",
                       want.status, want.entry_offset, want.pad_written, want.pad_offset,
                       want.segment_switched, want.head_index, want.used_count);
              $display("  actual   status=%0d offset=%h pad=%0d/%h switched=%0d head=%0d used=%0d",
                       rsp_o.status, rsp_o.entry_offset, rsp_o.pad_written, rsp_o.pad_offset,
                       rsp_o.segment_switched, rsp_o.head_index, rsp_o.used_count);
            end
          end
        end
      end
    end
  end

  // Watchdog: any item, result or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("** log_segment_append_allocator: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic void push_cmd(input logic cmd, input int unsigned len);
    lsa_req_t r;
    r.command      = cmd;
    r.entry_length = LEN_W'(len);
    pending_cmds.push_back(r);
  endfunction

  // Mostly appends, with an occasional format to refill the free chain.
  // Lengths favor small entries but reach the capacity edge and beyond.
  function automatic lsa_req_t random_cmd();
    lsa_req_t r;
    r.command = ($urandom_range(99) < 4) ? CMD_FORMAT : CMD_APPEND;
    case ($urandom_range(9))
      0, 1, 2, 3: r.entry_length = LEN_W'($urandom_range(255));
      4, 5, 6:    r.entry_length = LEN_W'($urandom_range(4056));
      7:          r.entry_length = LEN_W'($urandom_range(4095, 4030));
      default:    r.entry_length = LEN_W'($urandom_range(4095));
    endcase
    return r;
  endfunction

  // The sender holds off until every item sent so far has its result, and
  // then waits on before going ahead, so the block is surely idle.
  task automatic wait_all_results();
    while (pending_cmds.size() != 0 || cmds_issued != allocs_seen) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready; only called when idle.
  task automatic write_segment_count(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SEGMENT_COUNT;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seg_count_cfg = value;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned k;
    logic [CNT_W-1:0] count;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first on the reset count. An append before any format
    // finds no head and no free segment; an oversized entry is refused.
    idle_pct = 25;
    push_cmd(CMD_APPEND, 0);
    push_cmd(CMD_APPEND, 4095);
    push_cmd(CMD_FORMAT, 0);
    push_cmd(CMD_APPEND, 0);
    push_cmd(CMD_APPEND, 4056);   // does not fit behind the first entry: pad
    push_cmd(CMD_APPEND, 4040);   // head is exactly full: switch without pad
    push_cmd(CMD_APPEND, 4057);   // one byte over a segment
    wait_all_results();

    // Two segments: fill both exactly, then run the free chain dry and
    // append again with no head at all.
    write_segment_count(CNT_W'(2));
    push_cmd(CMD_FORMAT, 0);
    push_cmd(CMD_APPEND, 4056);
    push_cmd(CMD_APPEND, 0);
    push_cmd(CMD_APPEND, 4040);
    push_cmd(CMD_APPEND, 10);
    push_cmd(CMD_APPEND, 5);
    push_cmd(CMD_APPEND, 4057);
    wait_all_results();

    // A count of zero is clamped to one segment; the switch then writes a
    // pad but finds no free segment behind it.
    write_segment_count('0);
    push_cmd(CMD_FORMAT, 0);
    push_cmd(CMD_APPEND, 4000);
    push_cmd(CMD_APPEND, 50);
    push_cmd(CMD_APPEND, 1);
    wait_all_results();

    // The largest count clamps to the pool size.
    write_segment_count('1);
    push_cmd(CMD_FORMAT, 0);
    push_cmd(CMD_APPEND, 2048);
    push_cmd(CMD_APPEND, 1365);
    push_cmd(CMD_APPEND, 2730);
    wait_all_results();

    // Random part: every phase starts from a freshly formatted pool. Small
    // pools dominate so the free chain runs out often and formats stay short.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       count = CNT_W'(MaxSegments);
        1:       count = CNT_W'(1);
        2:       count = '1;
        3:       count = '0;
        7:       count = CNT_W'($urandom_range(64, 17));
        default: count = CNT_W'($urandom_range(16, 2));
      endcase
      // Sender idles a quarter of the time, then mostly, then never.
      idle_pct = (phase < 4) ? 25 : (phase < 8) ? 76 : 0;
      write_segment_count(count);
      push_cmd(CMD_FORMAT, $urandom_range(4095));
      for (k = 1; k < ITEMS_PER_PHASE; k++) pending_cmds.push_back(random_cmd());
      wait_all_results();
    end

    // Give a stray late result the chance to show up before judging.
    repeat (40) @(posedge clk_i);
    if (expected_allocs.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("** log_segment_append_allocator: PASSED **");
    end else begin
      $display("** log_segment_append_allocator: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lsa_pkg.sv
hdl/lsa_link_ram.sv
hdl/lsa_cfg_regs.sv
hdl/log_segment_append_allocator.sv
tb/sv/log_segment_append_allocator_tb.sv
